[rtl/laplacian_sharpness_metric_defines.svh]
// Assertion macros for the Laplacian sharpness block.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef LAPLACIAN_SHARPNESS_METRIC_DEFINES_SVH
`define LAPLACIAN_SHARPNESS_METRIC_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LSM_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define LSM_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LSM_ASSERT_IMP(label, clk, rst, pre, post)
`define LSM_ASSERT_NXT(label, clk, rst, pre, post)
`endif

`endif

[rtl/lsm_pkg.sv]
// Shared constants and types for the Laplacian sharpness block.
// No dependencies.
package lsm_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIXEL_W = 8;
  localparam int DIM_W   = 13;
  localparam int SUM_W   = 37;
  localparam int MEAN_W  = 21;
  localparam int FRAC_W  = 8;
  localparam int DVD_W   = SUM_W + FRAC_W;
  localparam int LAP_W   = 14;

  localparam int KERNEL_EDGE   = 4;
  localparam int KERNEL_CENTER = 20;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

[rtl/laplacian_sharpness_metric.sv]
// Laplacian sharpness metric: 3x3 focus measure over a raster frame.
// Depends on lsm_pkg and laplacian_sharpness_metric_defines.svh.
//
// Accepts one 8-bit pixel per clock in raster order. Both line stores share
// one 16-bit wide memory with a registered read; each pixel reads its column
// and writes it back in the next cycle, with a forwarding register
// for one-pixel-wide frames. Responses pass a 3-stage pipeline into the sum.
// After the last pixel of a frame the pixel input stalls until the result is
// taken: the pipeline drains, the mean is formed by a restoring divider (a
// load state, then one quotient bit per cycle), and the result beat is held
// until taken. Frames smaller than 3 in either dimension skip the divide.
`include "laplacian_sharpness_metric_defines.svh"

module laplacian_sharpness_metric
  import lsm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 pixel_valid,
  output logic                 pixel_stall,
  input  logic [PIXEL_W-1:0]   pixel,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [MEAN_W-1:0]    sharpness,
  output logic [SUM_W-1:0]     abs_sum
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW + RW;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int LINE_W = 2 * PIXEL_W;

  typedef enum logic [3:0] {
    ST_RUN    = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_SEND   = 4'b1000
  } state_t;

  state_t state;

  logic [CW-1:0] width_m1;
  logic [RW-1:0] height_m1;
  logic [AW-1:0] area;
  logic          small_frame;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic          frame_done;

  logic cfg_acc, pixel_acc, result_acc;
  logic col_end, row_end;

  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] line_rd;
  logic              fwd_hit;
  logic [LINE_W-1:0] fwd_data;

  logic               s1_valid, s1_interior, s1_last;
  logic [PIXEL_W-1:0] s1_px;
  logic [CW-1:0]      s1_addr;
  logic [LINE_W-1:0]  s1_line;
  logic [PIXEL_W-1:0] s1_top, s1_mid;

  logic [PIXEL_W-1:0] win [3][3];

  logic s2_valid, s2_interior, s2_last;
  logic [PIXEL_W+1:0] corner_sum, edge_sum;
  logic [LAP_W-1:0]   lap;
  logic [LAP_W-2:0]   lap_abs;

  logic             s3_valid, s3_interior, s3_last;
  logic [LAP_W-2:0] s3_lap;

  logic [SUM_W-1:0] sum;

  logic [DVD_W-1:0] dvd;
  logic [AW-1:0]    rem;
  logic [CNT_W-1:0] div_cnt;
  logic [AW:0]      rem_shift;
  logic             q_bit;
  logic [SUM_W-1:0] sum_hold;

  // writes wait until no pixel is in the pipeline and no finished frame awaits its result
  assign cfg_ready   = !frame_done && !s1_valid && !s2_valid && !s3_valid;
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign pixel_stall = frame_done;
  assign pixel_acc   = pixel_valid && !pixel_stall;
  assign result_valid = (state == ST_SEND);
  assign result_acc  = result_valid && !result_stall;

  assign col_end = (col == width_m1);
  assign row_end = (row == height_m1);

  // configuration: store effective dimension minus one
  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= '0;
      height_m1 <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            width_m1 <= '0;
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            width_m1 <= CW'(MAX_WIDTH - 1);
          end else begin
            width_m1 <= CW'(cfg_data - 1'b1);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            height_m1 <= '0;
          end else if (32'(cfg_data) > MAX_HEIGHT) begin
            height_m1 <= RW'(MAX_HEIGHT - 1);
          end else begin
            height_m1 <= RW'(cfg_data - 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    small_frame <= (width_m1 < CW'(2)) || (height_m1 < RW'(2));
    area        <= AW'(width_m1 - 1'b1) * AW'(height_m1 - 1'b1);
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      col <= '0;
      row <= '0;
    end else if (pixel_acc) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_done <= 1'b0;
    end else if (pixel_acc && col_end && row_end) begin
      frame_done <= 1'b1;
    end else if (result_acc) begin
      frame_done <= 1'b0;
    end
  end

  // line store: {upper, middle} per column
  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      line_rd <= line_mem[col];
    end
    if (s1_valid) begin
      line_mem[s1_addr] <= {s1_mid, s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      fwd_hit  <= s1_valid && (s1_addr == col);
      fwd_data <= {s1_mid, s1_px};
    end
  end

  assign s1_line = fwd_hit ? fwd_data : line_rd;
  assign s1_top  = s1_line[LINE_W-1:PIXEL_W];
  assign s1_mid  = s1_line[PIXEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= pixel_acc;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_acc) begin
      s1_px       <= pixel;
      s1_addr     <= col;
      s1_interior <= (col >= CW'(2)) && (row >= RW'(2));
      s1_last     <= col_end && row_end;
    end
  end

  // window shift, newest column on the right
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2]   <= s1_top;
      win[1][2]   <= s1_mid;
      win[2][2]   <= s1_px;
      s2_interior <= s1_interior;
      s2_last     <= s1_last;
    end
  end

  assign corner_sum = (PIXEL_W+2)'(win[0][0]) + (PIXEL_W+2)'(win[0][2])
                    + (PIXEL_W+2)'(win[2][0]) + (PIXEL_W+2)'(win[2][2]);
  assign edge_sum   = (PIXEL_W+2)'(win[0][1]) + (PIXEL_W+2)'(win[1][0])
                    + (PIXEL_W+2)'(win[1][2]) + (PIXEL_W+2)'(win[2][1]);
  assign lap = LAP_W'(corner_sum) + LAP_W'(edge_sum * KERNEL_EDGE)
             - LAP_W'(win[1][1] * KERNEL_CENTER);
  always_comb begin
    if (lap[LAP_W-1]) begin
      lap_abs = (LAP_W-1)'(-lap);
    end else begin
      lap_abs = lap[LAP_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_lap      <= lap_abs;
      s3_interior <= s2_interior;
      s3_last     <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_acc || state == ST_LOAD) begin
      sum <= '0;
    end else if (s3_valid && s3_interior) begin
      sum <= sum + SUM_W'(s3_lap);
    end
  end

  // restoring divider step
  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, area});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      unique case (state)
        ST_RUN: begin
          if (s3_valid && s3_last) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= small_frame ? ST_SEND : ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_cnt == CNT_W'(DVD_W - 1)) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!result_stall) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      dvd      <= small_frame ? '0 : {sum, FRAC_W'(0)};
      sum_hold <= small_frame ? '0 : sum;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (state == ST_DIVIDE) begin
      dvd     <= {dvd[DVD_W-2:0], q_bit};
      rem     <= q_bit ? AW'(rem_shift - {1'b0, area}) : AW'(rem_shift);
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign sharpness = (|dvd[DVD_W-1:MEAN_W]) ? '1 : dvd[MEAN_W-1:0];
  assign abs_sum   = sum_hold;

  `LSM_ASSERT_IMP(a_result_holds_input, clk, rst, result_valid, pixel_stall)
  `LSM_ASSERT_IMP(a_pixel_only_in_run, clk, rst, pixel_acc, state == ST_RUN)
  `LSM_ASSERT_IMP(a_rem_below_area, clk, rst, state == ST_DIVIDE, rem < area)
  `LSM_ASSERT_NXT(a_sum_cleared, clk, rst, state == ST_LOAD, sum == '0)

endmodule

[tb/sv/laplacian_sharpness_metric_test.sv]
// Self-checking testbench for laplacian_sharpness_metric: random and directed frames,
// checked beat by beat against an in-bench model of the 3x3 Laplacian focus measure.
// Depends on lsm_pkg and the laplacian_sharpness_metric RTL.
`timescale 1ns / 100ps

module laplacian_sharpness_metric_test
  import lsm_pkg::*;
();

  localparam int RANDOM_ITEMS = 1300;
  localparam int MIN_FRAMES   = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG     = 4000;

  typedef struct packed {
    logic [MEAN_W-1:0] sharpness;
    logic [SUM_W-1:0]  abs_sum;
  } focus_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [PIXEL_W-1:0]   pixel = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [MEAN_W-1:0]    sharpness;
  logic [SUM_W-1:0]     abs_sum;

  // bench model state
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  bit   [PIXEL_W-1:0] upper_store [DEF_MAX_WIDTH];
  bit   [PIXEL_W-1:0] middle_store [DEF_MAX_WIDTH];
  int                 win [3][3];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [SUM_W-1:0]   running_sum;

  focus_result_t      expected_focus_q[$];
  logic [PIXEL_W-1:0] pixel_backlog[$];

  int error_count = 0;
  int idle_pct = 14;
  int hold_asked = 0;
  int hold_granted = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int cur_w = 0;
  int cur_h = 0;

  laplacian_sharpness_metric u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sharpness    (sharpness),
    .abs_sum      (abs_sum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned effective_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = 0;
    col_pos = 0;
    row_pos = 0;
    running_sum = '0;
  endtask

  task automatic accumulate_laplacian(input logic [PIXEL_W-1:0] px);
    int unsigned w, h, c, r;
    int top, mid, resp;
    longint unsigned area, mean;
    focus_result_t res;
    w = effective_dim(width_reg, DEF_MAX_WIDTH);
    h = effective_dim(height_reg, DEF_MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    top = upper_store[c];
    mid = middle_store[c];
    upper_store[c] = mid[PIXEL_W-1:0];
    middle_store[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (r >= 2 && c >= 2) begin
      resp = win[0][0] + KERNEL_EDGE * win[0][1] + win[0][2]
           + KERNEL_EDGE * win[1][0] - KERNEL_CENTER * win[1][1] + KERNEL_EDGE * win[1][2]
           + win[2][0] + KERNEL_EDGE * win[2][1] + win[2][2];
      if (resp < 0) resp = -resp;
      running_sum = running_sum + SUM_W'(resp);
    end
    if (c + 1 < w) begin
      col_pos = c + 1;
      row_pos = r;
      return;
    end
    col_pos = 0;
    if (r + 1 < h) begin
      row_pos = r + 1;
      return;
    end
    // last pixel of the frame
    res = '0;
    if (w >= 3 && h >= 3) begin
      area = longint'(w - 2) * longint'(h - 2);
      mean = (64'(running_sum) << FRAC_W) / area;
      if (mean > (64'd1 << MEAN_W) - 1) mean = (64'd1 << MEAN_W) - 1;
      res.sharpness = mean[MEAN_W-1:0];
      res.abs_sum = running_sum;
    end
    expected_focus_q.push_back(res);
    restart_frame();
  endtask

  // monitor and scoreboard
  always @(posedge clk) begin
    focus_result_t exp_res;
    if (rst) begin
      width_reg = '0;
      height_reg = '0;
      restart_frame();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_focus_q.size() == 0) begin
          note_error($sformatf("unexpected result beat: sharpness %0d abs_sum %0d",
                               sharpness, abs_sum));
        end else begin
          exp_res = expected_focus_q.pop_front();
          if (sharpness !== exp_res.sharpness)
            note_error($sformatf("sharpness expected %0d got %0d",
                                 exp_res.sharpness, sharpness));
          if (abs_sum !== exp_res.abs_sum)
            note_error($sformatf("abs_sum expected %0d got %0d", exp_res.abs_sum, abs_sum));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH: width_reg = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
        restart_frame();
      end
      if (pixel_valid && !pixel_stall) accumulate_laplacian(pixel);
    end
  end

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || !pixel_stall) begin
      if (pixel_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        pixel_valid <= 1'b1;
        pixel <= pixel_backlog.pop_front();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_granted != hold_asked) begin
      hold_granted <= hold_asked;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(data);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_dims(input int w, input int h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cur_w = w;
    cur_h = h;
  endtask

  function automatic int frame_area();
    return effective_dim(DIM_W'(cur_w), DEF_MAX_WIDTH) *
           effective_dim(DIM_W'(cur_h), DEF_MAX_HEIGHT);
  endfunction

  task automatic push_frame(input int count, input bit extremes);
    for (int i = 0; i < count; i++) begin
      if (extremes) pixel_backlog.push_back($urandom_range(1) ? 8'hFF : 8'h00);
      else pixel_backlog.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_backlog.size() != 0 || pixel_valid || expected_focus_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h, sel, nframes, phase, frames_done, random_items, area, part;
    bit ext;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero dimensions out of reset: 1x1 frame
    pixel_backlog.push_back(8'hFF);
    wait_idle();

    // 3x3: bright ring around dark center, then a restart mid-frame, then the inverse
    write_dims(3, 3);
    for (int i = 0; i < 9; i++) pixel_backlog.push_back((i == 4) ? 8'h00 : 8'hFF);
    push_frame(4, 1'b0);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 3);
    for (int i = 0; i < 9; i++) pixel_backlog.push_back((i == 4) ? 8'hFF : 8'h00);
    wait_idle();

    // width below 3
    write_dims(1, 2);
    push_frame(2, 1'b0);
    wait_idle();

    // oversized values clamp; frame abandoned by the next write
    write_dims(8191, 8191);
    push_frame(64, 1'b0);
    wait_idle();

    phase = 0;
    frames_done = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS || frames_done < MIN_FRAMES) begin
      if ($urandom_range(99) < 85) begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 8);
      end else if ($urandom_range(1)) begin
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 2);
      end else begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 6);
      end
      sel = (phase == 0) ? 0 : $urandom_range(3);
      if (sel == 1 || sel == 3) h = cur_h;
      if (sel == 2 || sel == 3) w = cur_w;
      if (sel == 0 || sel == 1) write_reg(REG_FRAME_WIDTH, w);
      if (sel == 0 || sel == 2) write_reg(REG_FRAME_HEIGHT, h);
      cur_w = w;
      cur_h = h;
      area = frame_area();

      // abandoned frame, restarted by a register write
      if ($urandom_range(9) == 0 && area > 1) begin
        part = $urandom_range(1, area - 1);
        push_frame(part, 1'b0);
        random_items += part;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, cur_w);
      end

      if (phase == 3) idle_pct = 0;
      if (phase == 6) begin
        hold_asked++;
        nframes = 6;
      end else if (phase == 3) begin
        nframes = 8;
      end else begin
        nframes = $urandom_range(1, 4);
      end
      ext = ($urandom_range(3) == 0);
      repeat (nframes) push_frame(area, ext);
      random_items += nframes * area;
      frames_done += nframes;
      wait_idle();
      idle_pct = 14;
      phase++;
    end

    wait_idle();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/lsm_pkg.sv
rtl/laplacian_sharpness_metric.sv
tb/sv/laplacian_sharpness_metric_test.sv
